@@ rtl/core/hms_pkg.sv @@
package hms_pkg;

	localparam int VAL_BITS = 32;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SEG,
		ST_RD,
		ST_WR,
		ST_OUT
	} state_t;

	// write enables of the two banks
	typedef struct packed {
		logic we0;
		logic we1;
	} mem_we_t;

	// control that travels with one read result
	typedef struct packed {
		logic vld;
		logic last;
		logic ovf;
	} res_ctl_t;

endpackage

@@ rtl/core/hybrid_merge_insertion_sorter_core.sv @@
// Batch sorter. Feed a batch with start, one value per cycle while busy is low,
// and mark its final value with is_last. The block then raises busy, sorts with a
// bottom-up merge over two ping-pong memory banks using a single comparator, and
// emits the batch in ascending order, one value per cycle on strobe, the final one
// with is_last_res. Results cannot be stalled: sample them whenever strobe is high.
// Sorting n items takes ceil(log2 n) merge passes; in each pass every item is read
// from a bank (ST_RD) and then compared and written (ST_WR), and each pair of runs
// first has its bounds set (ST_SEG). Output then runs at one item per cycle, read
// from the bank register into the output register, and busy drops once the last
// read has been issued. Values past MAX_ITEMS are dropped and overflow is set on
// every result of that batch.
module hybrid_merge_insertion_sorter_core #(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [hms_pkg::VAL_BITS-1:0] value,
	input  logic                                is_last,
	output logic                                strobe,
	output logic signed [hms_pkg::VAL_BITS-1:0] sorted_value,
	output logic                                is_last_res,
	output logic                                overflow
);
	import hms_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int SW = (VALUE_WIDTH < VAL_BITS) ? VALUE_WIDTH : VAL_BITS;

	mem_we_t       mem_we;
	res_ctl_t      res_ctl;
	logic [AW-1:0] waddr, ra, rb;
	logic [SW-1:0] wdata, ld_value, res_data;
	logic [SW-1:0] q0a, q0b, q1a, q1b;
	logic          strobe_q, last_q, ovf_q;
	logic [VAL_BITS-1:0] data_q;

	// keep only the value bits, as the store holds them
	assign ld_value = value[SW-1:0];

	hms_seq #(
		.MAX_ITEMS   (MAX_ITEMS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.is_last  (is_last),
		.ld_value (ld_value),
		.busy     (busy),
		.mem_we   (mem_we),
		.waddr    (waddr),
		.wdata    (wdata),
		.ra       (ra),
		.rb       (rb),
		.q0a      (q0a),
		.q0b      (q0b),
		.q1a      (q1a),
		.q1b      (q1b),
		.res_ctl  (res_ctl),
		.res_data (res_data)
	);

	hms_mem #(
		.DEPTH (MAX_ITEMS),
		.AW    (AW),
		.DW    (SW)
	) u_element_store (
		.clk   (clk),
		.we    (mem_we.we0),
		.waddr (waddr),
		.wdata (wdata),
		.ra    (ra),
		.rb    (rb),
		.qa    (q0a),
		.qb    (q0b)
	);

	hms_mem #(
		.DEPTH (MAX_ITEMS),
		.AW    (AW),
		.DW    (SW)
	) u_merge_scratch (
		.clk   (clk),
		.we    (mem_we.we1),
		.waddr (waddr),
		.wdata (wdata),
		.ra    (ra),
		.rb    (rb),
		.qa    (q1a),
		.qb    (q1b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			strobe_q <= res_ctl.vld;
			last_q   <= res_ctl.vld & res_ctl.last;
			ovf_q    <= res_ctl.vld & res_ctl.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ctl.vld) begin
			data_q <= VAL_BITS'(res_data);
		end
	end

	assign strobe       = strobe_q;
	assign sorted_value = data_q;
	assign is_last_res  = last_q;
	assign overflow     = ovf_q;

endmodule

@@ rtl/core/hms_mem.sv @@
module hms_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] ra,
	input  logic [AW-1:0] rb,
	output logic [DW-1:0] qa,
	output logic [DW-1:0] qb
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		qa <= mem[ra];
		qb <= mem[rb];
	end

endmodule

@@ rtl/core/hms_seq.sv @@
module hms_seq #(
	parameter int MAX_ITEMS   = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int AW = $clog2(MAX_ITEMS),
	localparam int SW = (VALUE_WIDTH < hms_pkg::VAL_BITS) ? VALUE_WIDTH : hms_pkg::VAL_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      is_last,
	input  logic [SW-1:0]             ld_value,
	output logic                      busy,
	output hms_pkg::mem_we_t          mem_we,
	output logic [AW-1:0]             waddr,
	output logic [SW-1:0]             wdata,
	output logic [AW-1:0]             ra,
	output logic [AW-1:0]             rb,
	input  logic [SW-1:0]             q0a,
	input  logic [SW-1:0]             q0b,
	input  logic [SW-1:0]             q1a,
	input  logic [SW-1:0]             q1b,
	output hms_pkg::res_ctl_t         res_ctl,
	output logic [SW-1:0]             res_data
);
	import hms_pkg::*;

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int PW = CW + 2;
	// sign bit lies inside the stored word only when VALUE_WIDTH fits the port
	localparam logic FLIP = (VALUE_WIDTH <= VAL_BITS) ? 1'b1 : 1'b0;

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic ovf_q, ovf_d;
	logic bank_q, bank_d;
	logic [PW-1:0] w_q, w_d, lo_q, lo_d, mid_q, mid_d, hi_q, hi_d;
	logic [PW-1:0] a_q, a_d, b_q, b_d, k_q, k_d;
	logic [PW-1:0] nx, sum_mid, sum_hi, w_dbl;
	logic rvld_q, rvld_d, rlast_q, rlast_d, rovf_q, rovf_d;
	logic [SW-1:0] src_a, src_b, key_a, key_b;
	logic take_left;

	assign nx      = PW'(cnt_q);
	assign sum_mid = lo_q + w_q;
	assign w_dbl   = w_q << 1;
	assign sum_hi  = lo_q + w_dbl;
	assign src_a   = bank_q ? q1a : q0a;
	assign src_b   = bank_q ? q1b : q0b;
	assign key_a   = {src_a[SW-1] ^ FLIP, src_a[SW-2:0]};
	assign key_b   = {src_b[SW-1] ^ FLIP, src_b[SW-2:0]};
	assign take_left = (a_q < mid_q) && ((b_q >= hi_q) || (key_a <= key_b));

	assign busy     = (state_q != ST_LOAD);
	assign res_data = src_a;
	assign res_ctl  = '{vld: rvld_q, last: rlast_q, ovf: rovf_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= 1'b0;
			w_q     <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
			rvld_q  <= 1'b0;
			rlast_q <= 1'b0;
			rovf_q  <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			bank_q  <= bank_d;
			w_q     <= w_d;
			lo_q    <= lo_d;
			mid_q   <= mid_d;
			hi_q    <= hi_d;
			a_q     <= a_d;
			b_q     <= b_d;
			k_q     <= k_d;
			rvld_q  <= rvld_d;
			rlast_q <= rlast_d;
			rovf_q  <= rovf_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		bank_d  = bank_q;
		w_d     = w_q;
		lo_d    = lo_q;
		mid_d   = mid_q;
		hi_d    = hi_q;
		a_d     = a_q;
		b_d     = b_q;
		k_d     = k_q;
		rvld_d  = 1'b0;
		rlast_d = 1'b0;
		rovf_d  = rovf_q;
		mem_we  = '0;
		waddr   = k_q[AW-1:0];
		wdata   = ld_value;
		ra      = a_q[AW-1:0];
		rb      = b_q[AW-1:0];
		case (state_q)
			ST_LOAD: begin
				if (start) begin
					waddr = cnt_q[AW-1:0];
					if (cnt_q < CW'(MAX_ITEMS)) begin
						mem_we.we0 = 1'b1;
						cnt_d      = cnt_q + CW'(1);
					end else begin
						ovf_d = 1'b1;
					end
					if (is_last) begin
						lo_d   = '0;
						k_d    = '0;
						w_d    = PW'(1);
						bank_d = 1'b0;
						state_d = (cnt_d < CW'(2)) ? ST_OUT : ST_SEG;
					end
				end
			end
			ST_SEG: begin
				// clip both runs of this pair at the batch end
				mid_d   = (sum_mid < nx) ? sum_mid : nx;
				hi_d    = (sum_hi < nx) ? sum_hi : nx;
				a_d     = lo_q;
				b_d     = mid_d;
				k_d     = lo_q;
				state_d = ST_RD;
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				wdata = take_left ? src_a : src_b;
				if (bank_q) begin
					mem_we.we0 = 1'b1;
				end else begin
					mem_we.we1 = 1'b1;
				end
				if (take_left) begin
					a_d = a_q + PW'(1);
				end else begin
					b_d = b_q + PW'(1);
				end
				k_d = k_q + PW'(1);
				if (k_q + PW'(1) == hi_q) begin
					if (hi_q == nx) begin
						// pass done: swap banks and double the run length
						w_d     = w_dbl;
						bank_d  = ~bank_q;
						lo_d    = '0;
						k_d     = '0;
						state_d = (w_dbl >= nx) ? ST_OUT : ST_SEG;
					end else begin
						lo_d    = hi_q;
						state_d = ST_SEG;
					end
				end else begin
					state_d = ST_RD;
				end
			end
			ST_OUT: begin
				ra      = k_q[AW-1:0];
				rvld_d  = 1'b1;
				rlast_d = (k_q + PW'(1) == nx);
				rovf_d  = ovf_q;
				k_d     = k_q + PW'(1);
				if (k_q + PW'(1) == nx) begin
					cnt_d   = '0;
					ovf_d   = 1'b0;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	a_src_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (a_q < mid_q || b_q < hi_q))
		else $error("merge step with both runs empty");

	a_k_track: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (k_q + mid_q == a_q + b_q))
		else $error("merge output index out of step with run heads");

	a_rvld_src: assert property (@(posedge clk) disable iff (!arst_n)
		rvld_q |-> $past(state_q == ST_OUT))
		else $error("result read without output phase");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITEMS))
		else $error("item count beyond store depth");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rvld_q && rlast_q) |-> (state_q == ST_LOAD && cnt_q == '0))
		else $error("final result while batch state still live");

endmodule

@@ verif/tb_hybrid_merge_insertion_sorter_core.sv @@
module tb_hybrid_merge_insertion_sorter_core;
	import hms_pkg::*;

	localparam int STORE_DEPTH  = 64;
	localparam int RANDOM_ITEMS = 100;
	localparam int IDLE_LIMIT   = 8000;
	localparam int DRAIN_CYCLES = 20;
	localparam int DIR_ROWS     = 18;

	typedef enum int {MIX_FULL, MIX_NARROW, MIX_EDGES} value_mix_t;

	typedef struct packed {
		logic [VAL_BITS-1:0] val;
		logic                last;
		logic                ovf;
	} sorted_item_t;

	// fill: random non-last items sent ahead of the row's own item
	typedef struct packed {
		int unsigned         fill;
		logic [VAL_BITS-1:0] val;
		logic                last;
		logic                typed;
		logic [VAL_BITS-1:0] exp_val;
		logic                exp_ovf;
	} stim_row_t;

	stim_row_t dir_rows [DIR_ROWS] = '{
		'{0,  32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, 1'b0},
		'{0,  32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
		'{0,  32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
		'{0,  32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff, 1'b0},
		'{0,  32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0},
		'{0,  32'hffff_fffd, 1'b0, 1'b0, 32'h0, 1'b0},
		'{0,  32'h7fff_ffff, 1'b0, 1'b0, 32'h0, 1'b0},
		'{0,  32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
		'{0,  32'h0000_0005, 1'b0, 1'b0, 32'h0, 1'b0},
		'{0,  32'hffff_ffff, 1'b1, 1'b0, 32'h0, 1'b0},
		'{0,  32'h0000_0001, 1'b0, 1'b0, 32'h0, 1'b0},
		'{0,  32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0},
		'{0,  32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0},
		'{0,  32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0},
		'{63, 32'h55aa_55aa, 1'b1, 1'b0, 32'h0, 1'b0},
		'{64, 32'h1234_5678, 1'b1, 1'b0, 32'h0, 1'b0},
		'{0,  32'h0000_002a, 1'b1, 1'b1, 32'h0000_002a, 1'b0},
		'{66, 32'hdead_beef, 1'b1, 1'b0, 32'h0, 1'b0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic signed [VAL_BITS-1:0] value;
	logic                       is_last;
	logic                       strobe;
	logic signed [VAL_BITS-1:0] sorted_value;
	logic                       is_last_res;
	logic                       overflow;

	logic signed [VAL_BITS-1:0] batch_vals[$];
	logic                       batch_ovf = 1'b0;
	sorted_item_t               sorted_due[$];
	logic                       sender_idles = 1'b0;
	int unsigned                err_count = 0;
	int unsigned                items_sent = 0;
	int unsigned                batch_count = 0;
	int unsigned                ovf_batches = 0;
	int unsigned                result_count = 0;
	int unsigned                idle_cycles = 0;

	hybrid_merge_insertion_sorter_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.is_last      (is_last),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.is_last_res  (is_last_res),
		.overflow     (overflow)
	);

	always #5 clk = ~clk;

	function automatic int unsigned draw_gap();
		return sender_idles ? $urandom_range(0, 8) : 0;
	endfunction

	// Store one accepted item; on the last one, sort the batch and queue its results.
	task automatic load_and_sort(input logic [VAL_BITS-1:0] v, input logic l,
		input logic typed, input sorted_item_t typed_res);
		logic signed [VAL_BITS-1:0] pick;
		int i;
		sorted_item_t res;
		if (batch_vals.size() < STORE_DEPTH)
			batch_vals.push_back(v);
		else
			batch_ovf = 1'b1;
		items_sent++;
		if (l) begin
			for (int j = 1; j < batch_vals.size(); j++) begin
				pick = batch_vals[j];
				i = j;
				while (i > 0 && batch_vals[i-1] > pick) begin
					batch_vals[i] = batch_vals[i-1];
					i--;
				end
				batch_vals[i] = pick;
			end
			if (typed) begin
				sorted_due.push_back(typed_res);
			end else begin
				foreach (batch_vals[k]) begin
					res.val  = batch_vals[k];
					res.last = (k == batch_vals.size() - 1);
					res.ovf  = batch_ovf;
					sorted_due.push_back(res);
				end
			end
			if (batch_ovf)
				ovf_batches++;
			batch_count++;
			batch_vals.delete();
			batch_ovf = 1'b0;
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic [VAL_BITS-1:0] v, input logic l,
		input int unsigned gap, input logic typed, input sorted_item_t typed_res);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		value   <= v;
		is_last <= l;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		load_and_sort(v, l, typed, typed_res);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		sorted_item_t want;
		if (arst_n) begin
			if ((start && !busy) || strobe)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (strobe) begin
				result_count++;
				if (sorted_due.size() == 0) begin
					$display("%0t: unexpected result: sorted_value %h is_last_res %b overflow %b",
						$time, sorted_value, is_last_res, overflow);
					err_count++;
				end else begin
					want = sorted_due.pop_front();
					if (sorted_value !== want.val) begin
						$display("%0t: sorted_value expected %h actual %h",
							$time, want.val, sorted_value);
						err_count++;
					end
					if (is_last_res !== want.last) begin
						$display("%0t: is_last_res expected %b actual %b",
							$time, want.last, is_last_res);
						err_count++;
					end
					if (overflow !== want.ovf) begin
						$display("%0t: overflow expected %b actual %b",
							$time, want.ovf, overflow);
						err_count++;
					end
				end
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("%0t: no item or result moved for %0d cycles", $time, IDLE_LIMIT);
		$display("tb_hybrid_merge_insertion_sorter_core: done, errors");
		$finish;
	end

	initial begin
		int unsigned n;
		int unsigned sent;
		value_mix_t mix;
		logic [VAL_BITS-1:0] v;
		sorted_item_t typed_res;
		arst_n  = 1'b0;
		start   = 1'b0;
		value   = '0;
		is_last = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_idles = 1'b1;
		foreach (dir_rows[r]) begin
			repeat (dir_rows[r].fill)
				send_item($urandom, 1'b0, draw_gap(), 1'b0, '0);
			typed_res = '{val: dir_rows[r].exp_val, last: 1'b1, ovf: dir_rows[r].exp_ovf};
			send_item(dir_rows[r].val, dir_rows[r].last, draw_gap(), dir_rows[r].typed,
				typed_res);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 19))
				0:              n = $urandom_range(65, 72);
				1, 2:           n = $urandom_range(60, 64);
				3, 4, 5:        n = $urandom_range(13, 40);
				default:        n = $urandom_range(1, 12);
			endcase
			mix = value_mix_t'($urandom_range(0, 2));
			sender_idles = ($urandom_range(0, 2) != 0);
			for (int k = 0; k < n; k++) begin
				case (mix)
					MIX_NARROW: v = $urandom_range(0, 8) - 4;
					MIX_EDGES: begin
						case ($urandom_range(0, 4))
							0:       v = 32'h8000_0000;
							1:       v = 32'h7fff_ffff;
							2:       v = '0;
							3:       v = '1;
							default: v = $urandom;
						endcase
					end
					default:    v = $urandom;
				endcase
				send_item(v, k == n - 1, draw_gap(), 1'b0, '0);
			end
			sent += n;
		end
		start <= 1'b0;

		while (sorted_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sorted %0d batches from %0d items, %0d of them past the store depth",
			batch_count, items_sent, ovf_batches);
		$display("checked %0d results, %0d mismatches", result_count, err_count);
		if (err_count == 0 && sorted_due.size() == 0)
			$display("tb_hybrid_merge_insertion_sorter_core: done, clean");
		else
			$display("tb_hybrid_merge_insertion_sorter_core: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/hms_pkg.sv
rtl/core/hms_mem.sv
rtl/core/hms_seq.sv
rtl/core/hybrid_merge_insertion_sorter_core.sv
verif/tb_hybrid_merge_insertion_sorter_core.sv
